// ===== src/dcs_pkg.sv =====
package dcs_pkg;

  // Fixed-point format and derived widths
  localparam int FRAC_BITS = 16;
  localparam int POS_W     = 32;
  localparam int MAG_W     = 32;
  localparam int SQ_W      = 2 * MAG_W;
  localparam int SUM_W     = SQ_W + 2;
  localparam int ROOT_W    = (SUM_W + 1) / 2;
  localparam int REM_W     = 2 * ROOT_W;
  localparam int REST_W    = 31;
  localparam int MW_W      = 24;
  localparam int WS_W      = MW_W + 1;
  localparam int RA_W      = WS_W + 1;
  localparam int MQ_W      = FRAC_BITS + 1;
  localparam int GAP_W     = ROOT_W;
  localparam int NUM_W     = GAP_W + FRAC_BITS;
  localparam int QLO_W     = NUM_W / 2;
  localparam int QHI_W     = NUM_W - QLO_W;
  localparam int QP_W      = NUM_W + MQ_W;
  localparam int T_W       = QP_W - FRAC_BITS;
  localparam int TLO_W     = (T_W + 1) / 2;
  localparam int THI_W     = T_W - TLO_W;
  localparam int CP_W      = MAG_W + T_W;
  localparam int CAP_BIT   = 40;
  localparam int CORR_W    = CAP_BIT + 1;
  localparam int ACC_W     = CORR_W + 2;
  localparam int LATENCY   = ROOT_W + NUM_W + 10;

  // Payload carried along the whole pipeline
  typedef struct packed {
    logic [2:0][POS_W-1:0] pa;
    logic [2:0][POS_W-1:0] pb;
    logic [2:0][MAG_W-1:0] mag;
    logic [2:0]            dneg;
    logic [REST_W-1:0]     rest;
    logic                  skip;
  } cmn_t;

  // Square root and mass-fraction stage
  typedef struct packed {
    cmn_t              c;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [WS_W-1:0]   ws;
    logic [RA_W-1:0]   ra;
    logic [RA_W-1:0]   rb;
    logic [MQ_W-1:0]   ma;
    logic [MQ_W-1:0]   mb;
    logic              wa0;
    logic              wb0;
  } sqs_t;

  // Ratio divider stage
  typedef struct packed {
    cmn_t              c;
    logic [MQ_W-1:0]   ma;
    logic [MQ_W-1:0]   mb;
    logic              qneg;
    logic [NUM_W-1:0]  num;
    logic [ROOT_W-1:0] dvs;
    logic [ROOT_W-1:0] rem;
    logic [NUM_W-1:0]  q;
  } dvs_t;

  // Clamp a wide signed sum to the 32-bit position range
  function automatic logic [POS_W-1:0] sat_pos(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(signed'({1'b0, {(POS_W-1){1'b1}}}));
    lo = -hi - ACC_W'(1);
    if (v > hi) begin
      sat_pos = {1'b0, {(POS_W-1){1'b1}}};
    end else if (v < lo) begin
      sat_pos = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      sat_pos = v[POS_W-1:0];
    end
  endfunction

endpackage

// ===== src/distance_constraint_solve_unit.sv =====
// Distance constraint solver for one spring per request. A request is taken at
// any clock edge with start high and busy low; busy is high only during reset
// and in the cycle after it, so a new request may follow in every cycle. Each
// request yields one result, strobed on done_o for a single cycle, in request
// order; the receiver cannot stall it. The pipeline holds the 33-stage
// bit-per-stage square root and the 49-stage bit-per-stage ratio divider, plus
// ten stages of capture, difference, squaring, multiplies, capping and clamping.
module distance_constraint_solve_unit import dcs_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [POS_W-1:0]  pos_a_x_i,
  input  logic signed [POS_W-1:0]  pos_a_y_i,
  input  logic signed [POS_W-1:0]  pos_a_z_i,
  input  logic signed [POS_W-1:0]  pos_b_x_i,
  input  logic signed [POS_W-1:0]  pos_b_y_i,
  input  logic signed [POS_W-1:0]  pos_b_z_i,
  input  logic        [MW_W-1:0]   inv_mass_a_i,
  input  logic        [MW_W-1:0]   inv_mass_b_i,
  input  logic        [REST_W-1:0] rest_length_i,
  output logic                     done_o,
  output logic signed [POS_W-1:0]  new_a_x_o,
  output logic signed [POS_W-1:0]  new_a_y_o,
  output logic signed [POS_W-1:0]  new_a_z_o,
  output logic signed [POS_W-1:0]  new_b_x_o,
  output logic signed [POS_W-1:0]  new_b_y_o,
  output logic signed [POS_W-1:0]  new_b_z_o,
  output logic                     skipped_o
);

  logic acc;
  logic busy_q;

  // Hold off requests until reset is over
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  assign busy = busy_q;
  assign acc  = start && !busy_q;

  // Stage a0: capture request
  logic                      a0_v_q;
  logic [2:0][POS_W-1:0]     a0_pa_q, a0_pb_q;
  logic [MW_W-1:0]           a0_wa_q, a0_wb_q;
  logic [REST_W-1:0]         a0_rest_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a0_v_q <= 1'b0;
    end else begin
      a0_v_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    a0_pa_q   <= {pos_a_z_i, pos_a_y_i, pos_a_x_i};
    a0_pb_q   <= {pos_b_z_i, pos_b_y_i, pos_b_x_i};
    a0_wa_q   <= inv_mass_a_i;
    a0_wb_q   <= inv_mass_b_i;
    a0_rest_q <= rest_length_i;
  end

  // Stage a1: difference and magnitude per axis
  logic              a1_v_q;
  cmn_t              a1_c_q;
  logic [MW_W-1:0]   a1_wa_q, a1_wb_q;
  cmn_t              a1_c_d;

  always_comb begin
    logic signed [POS_W:0] dv;
    a1_c_d      = '0;
    a1_c_d.pa   = a0_pa_q;
    a1_c_d.pb   = a0_pb_q;
    a1_c_d.rest = a0_rest_q;
    for (int i = 0; i < 3; i++) begin
      dv = signed'({a0_pb_q[i][POS_W-1], a0_pb_q[i]})
         - signed'({a0_pa_q[i][POS_W-1], a0_pa_q[i]});
      a1_c_d.dneg[i] = dv[POS_W];
      a1_c_d.mag[i]  = dv[POS_W] ? MAG_W'(-dv) : MAG_W'(dv);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a1_v_q <= 1'b0;
    end else begin
      a1_v_q <= a0_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a1_c_q  <= a1_c_d;
    a1_wa_q <= a0_wa_q;
    a1_wb_q <= a0_wb_q;
  end

  // Stage a2: squares and mass sum
  logic                  a2_v_q;
  cmn_t                  a2_c_q;
  logic [2:0][SQ_W-1:0]  a2_sq_q;
  logic [MW_W-1:0]       a2_wa_q, a2_wb_q;
  logic [WS_W-1:0]       a2_ws_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a2_v_q <= 1'b0;
    end else begin
      a2_v_q <= a1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a2_c_q <= a1_c_q;
    for (int i = 0; i < 3; i++) begin
      a2_sq_q[i] <= a1_c_q.mag[i] * a1_c_q.mag[i];
    end
    a2_wa_q <= a1_wa_q;
    a2_wb_q <= a1_wb_q;
    a2_ws_q <= WS_W'(a1_wa_q) + WS_W'(a1_wb_q);
  end

  // Square root pipeline, mass fractions in its first stages
  logic             sq_v_q [ROOT_W+1];
  sqs_t             sq_q   [ROOT_W+1];
  sqs_t             sq_in;

  always_comb begin
    sq_in       = '0;
    sq_in.c     = a2_c_q;
    sq_in.c.skip = (a2_ws_q == '0);
    sq_in.rem   = REM_W'(SUM_W'(a2_sq_q[0]) + SUM_W'(a2_sq_q[1]) + SUM_W'(a2_sq_q[2]));
    sq_in.ws    = (a2_ws_q == '0) ? WS_W'(1) : a2_ws_q;
    sq_in.ra    = RA_W'(a2_wa_q[MW_W-1:1]);
    sq_in.rb    = RA_W'(a2_wb_q[MW_W-1:1]);
    sq_in.wa0   = a2_wa_q[0];
    sq_in.wb0   = a2_wb_q[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q[0] <= 1'b0;
    end else begin
      sq_v_q[0] <= a2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q[0] <= sq_in;
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    localparam int B = ROOT_W - 1 - k;
    sqs_t             nx;
    logic [REM_W-1:0] trial;

    always_comb begin
      logic [RA_W-1:0] ta;
      logic [RA_W-1:0] tb;
      nx    = sq_q[k];
      trial = (REM_W'(sq_q[k].root) << (B + 1)) | (REM_W'(1) << (2 * B));
      if (sq_q[k].rem >= trial) begin
        nx.rem     = sq_q[k].rem - trial;
        nx.root[B] = 1'b1;
      end
      ta = '0;
      tb = '0;
      // One quotient bit per stage for each mass fraction
      if (k < MQ_W) begin
        ta = {sq_q[k].ra[WS_W-1:0], (k == 0) ? sq_q[k].wa0 : 1'b0};
        tb = {sq_q[k].rb[WS_W-1:0], (k == 0) ? sq_q[k].wb0 : 1'b0};
        nx.ra = ta;
        nx.rb = tb;
        if (ta >= RA_W'(sq_q[k].ws)) begin
          nx.ra = ta - RA_W'(sq_q[k].ws);
          nx.ma[(MQ_W - 1 - k) % MQ_W] = 1'b1;
        end
        if (tb >= RA_W'(sq_q[k].ws)) begin
          nx.rb = tb - RA_W'(sq_q[k].ws);
          nx.mb[(MQ_W - 1 - k) % MQ_W] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[k+1] <= 1'b0;
      end else begin
        sq_v_q[k+1] <= sq_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      sq_q[k+1] <= nx;
    end
  end

  // Ratio divider entry: gap = len - rest
  logic dv_v_q [NUM_W+1];
  dvs_t dv_q   [NUM_W+1];
  dvs_t dv_in;

  always_comb begin
    logic [ROOT_W-1:0]        len;
    logic signed [ROOT_W+1:0] gap;
    logic [GAP_W-1:0]         gmag;
    len        = sq_q[ROOT_W].root;
    gap        = signed'({2'b00, len}) - signed'((ROOT_W+2)'(sq_q[ROOT_W].c.rest));
    gmag       = gap[ROOT_W+1] ? GAP_W'(-gap) : GAP_W'(gap);
    dv_in      = '0;
    dv_in.c    = sq_q[ROOT_W].c;
    dv_in.c.skip = sq_q[ROOT_W].c.skip || (len == '0);
    dv_in.ma   = sq_q[ROOT_W].ma;
    dv_in.mb   = sq_q[ROOT_W].mb;
    dv_in.qneg = gap[ROOT_W+1];
    dv_in.num  = {gmag, {FRAC_BITS{1'b0}}};
    dv_in.dvs  = (len == '0) ? ROOT_W'(1) : len;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v_q[0] <= 1'b0;
    end else begin
      dv_v_q[0] <= sq_v_q[ROOT_W];
    end
  end

  always_ff @(posedge clk_i) begin
    dv_q[0] <= dv_in;
  end

  for (genvar k = 0; k < NUM_W; k++) begin : g_div
    localparam int QB = NUM_W - 1 - k;
    dvs_t nx;

    always_comb begin
      logic [ROOT_W:0] t;
      nx = dv_q[k];
      t  = {dv_q[k].rem, dv_q[k].num[QB]};
      nx.rem = t[ROOT_W-1:0];
      if (t >= {1'b0, dv_q[k].dvs}) begin
        nx.rem   = ROOT_W'(t - {1'b0, dv_q[k].dvs});
        nx.q[QB] = 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[k+1] <= 1'b0;
      end else begin
        dv_v_q[k+1] <= dv_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      dv_q[k+1] <= nx;
    end
  end

  // Stage d0: ratio times mass fraction, split in halves
  logic                        d0_v_q;
  cmn_t                        d0_c_q;
  logic                        d0_qneg_q;
  logic [QHI_W+MQ_W-1:0]       d0_ah_q, d0_bh_q;
  logic [QLO_W+MQ_W-1:0]       d0_al_q, d0_bl_q;

  // Stage d1: per-particle scales
  logic                        d1_v_q;
  cmn_t                        d1_c_q;
  logic                        d1_qneg_q;
  logic [T_W-1:0]              d1_ta_q, d1_tb_q;

  // Stage d2: axis products, split in halves
  logic                        d2_v_q;
  cmn_t                        d2_c_q;
  logic                        d2_qneg_q;
  logic [2:0][MAG_W+TLO_W-1:0] d2_al_q, d2_bl_q;
  logic [2:0][MAG_W+THI_W-1:0] d2_ah_q, d2_bh_q;

  // Stage d3: capped correction magnitudes
  logic                        d3_v_q;
  cmn_t                        d3_c_q;
  logic                        d3_qneg_q;
  logic [2:0][CORR_W-1:0]      d3_ca_q, d3_cb_q;
  logic [2:0][CORR_W-1:0]      d3_ca_d, d3_cb_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d0_v_q <= 1'b0;
      d1_v_q <= 1'b0;
      d2_v_q <= 1'b0;
      d3_v_q <= 1'b0;
    end else begin
      d0_v_q <= dv_v_q[NUM_W];
      d1_v_q <= d0_v_q;
      d2_v_q <= d1_v_q;
      d3_v_q <= d2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d0_c_q    <= dv_q[NUM_W].c;
    d0_qneg_q <= dv_q[NUM_W].qneg;
    d0_ah_q   <= dv_q[NUM_W].q[NUM_W-1:QLO_W] * dv_q[NUM_W].ma;
    d0_al_q   <= dv_q[NUM_W].q[QLO_W-1:0] * dv_q[NUM_W].ma;
    d0_bh_q   <= dv_q[NUM_W].q[NUM_W-1:QLO_W] * dv_q[NUM_W].mb;
    d0_bl_q   <= dv_q[NUM_W].q[QLO_W-1:0] * dv_q[NUM_W].mb;

    d1_c_q    <= d0_c_q;
    d1_qneg_q <= d0_qneg_q;
    d1_ta_q   <= T_W'(((QP_W'(d0_ah_q) << QLO_W) + QP_W'(d0_al_q)) >> FRAC_BITS);
    d1_tb_q   <= T_W'(((QP_W'(d0_bh_q) << QLO_W) + QP_W'(d0_bl_q)) >> FRAC_BITS);

    d2_c_q    <= d1_c_q;
    d2_qneg_q <= d1_qneg_q;
    for (int i = 0; i < 3; i++) begin
      d2_al_q[i] <= d1_c_q.mag[i] * d1_ta_q[TLO_W-1:0];
      d2_ah_q[i] <= d1_c_q.mag[i] * d1_ta_q[T_W-1:TLO_W];
      d2_bl_q[i] <= d1_c_q.mag[i] * d1_tb_q[TLO_W-1:0];
      d2_bh_q[i] <= d1_c_q.mag[i] * d1_tb_q[T_W-1:TLO_W];
    end

    d3_c_q    <= d2_c_q;
    d3_qneg_q <= d2_qneg_q;
    d3_ca_q   <= d3_ca_d;
    d3_cb_q   <= d3_cb_d;
  end

  // Rejoin halves, drop fraction bits, cap the correction
  always_comb begin
    logic [CP_W-1:0] pa;
    logic [CP_W-1:0] pb;
    for (int i = 0; i < 3; i++) begin
      pa = (CP_W'(d2_ah_q[i]) << TLO_W) + CP_W'(d2_al_q[i]);
      pb = (CP_W'(d2_bh_q[i]) << TLO_W) + CP_W'(d2_bl_q[i]);
      d3_ca_d[i] = (|pa[CP_W-1:CAP_BIT+FRAC_BITS]) ? (CORR_W'(1) << CAP_BIT)
                 : CORR_W'(pa[CAP_BIT+FRAC_BITS-1:FRAC_BITS]);
      d3_cb_d[i] = (|pb[CP_W-1:CAP_BIT+FRAC_BITS]) ? (CORR_W'(1) << CAP_BIT)
                 : CORR_W'(pb[CAP_BIT+FRAC_BITS-1:FRAC_BITS]);
    end
  end

  // Output stage: apply signed correction and clamp
  logic                  out_v_q;
  logic [2:0][POS_W-1:0] out_a_q, out_b_q;
  logic                  out_skip_q;
  logic [2:0][POS_W-1:0] out_a_d, out_b_d;

  always_comb begin
    logic signed [ACC_W-1:0] ca;
    logic signed [ACC_W-1:0] cb;
    logic                    neg;
    for (int i = 0; i < 3; i++) begin
      neg = d3_c_q.dneg[i] ^ d3_qneg_q;
      ca  = signed'(ACC_W'(d3_ca_q[i]));
      cb  = signed'(ACC_W'(d3_cb_q[i]));
      if (neg) begin
        ca = -ca;
        cb = -cb;
      end
      if (d3_c_q.skip) begin
        out_a_d[i] = d3_c_q.pa[i];
        out_b_d[i] = d3_c_q.pb[i];
      end else begin
        out_a_d[i] = sat_pos(ACC_W'(signed'(d3_c_q.pa[i])) + ca);
        out_b_d[i] = sat_pos(ACC_W'(signed'(d3_c_q.pb[i])) - cb);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= d3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    out_a_q    <= out_a_d;
    out_b_q    <= out_b_d;
    out_skip_q <= d3_c_q.skip;
  end

  assign done_o    = out_v_q;
  assign new_a_x_o = out_a_q[0];
  assign new_a_y_o = out_a_q[1];
  assign new_a_z_o = out_a_q[2];
  assign new_b_x_o = out_b_q[0];
  assign new_b_y_o = out_b_q[1];
  assign new_b_z_o = out_b_q[2];
  assign skipped_o = out_skip_q;

  // Every request comes out exactly once after the fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o || $past(acc, LATENCY)) |-> done_o == $past(acc, LATENCY))
    else $error("result strobe does not match request latency");

  // Both immovable particles must give a skipped result
  a_mass_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(acc && inv_mass_a_i == '0 && inv_mass_b_i == '0, LATENCY)
      |-> done_o && skipped_o)
    else $error("zero mass sum not skipped");

  // A skipped result passes the positions through
  a_skip_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && skipped_o |-> new_a_x_o == $past(pos_a_x_i, LATENCY)
                         && new_b_z_o == $past(pos_b_z_i, LATENCY))
    else $error("skipped result altered positions");

  // Coincident particles must give a skipped result
  a_len_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(acc && pos_a_x_i == pos_b_x_i && pos_a_y_i == pos_b_y_i
          && pos_a_z_i == pos_b_z_i, LATENCY) |-> done_o && skipped_o)
    else $error("zero length not skipped");

endmodule
